// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned CpW = 20;
  localparam int unsigned AccW = 31;
  localparam int unsigned PendW = 3;
  localparam int unsigned UnitW = 16;

  localparam logic [CpW-1:0] MaxPairCp = 20'hEFFFF;
  localparam logic [UnitW-1:0] HiSurrBase = 16'hD800;
  localparam logic [UnitW-1:0] LoSurrBase = 16'hDC00;
  localparam logic [UnitW-1:0] HiSurrAdj = 16'h0040;
  localparam logic [7:0] ContMask = 8'h3F;

  typedef struct packed {
    logic [CpW-1:0] cp;
  } cp_entry_t;

endpackage

// File: rtl/u8u16_front.sv
module u8u16_front import u8u16_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cp_entry_t  q_entry_o
);

  logic [PendW-1:0] pend_q, pend_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [AccW-1:0]  acc_next;
  logic [AccW-1:0]  cp_full;
  logic             emit;
  logic             is_cont;
  logic             accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign is_cont    = (in_byte_i[7:6] == 2'b10);
  assign acc_next   = {acc_q[AccW-7:0], in_byte_i[5:0] & ContMask[5:0]};

  always_comb begin
    pend_d  = pend_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    cp_full = '0;
    if (accept) begin
      if (pend_q != '0 && is_cont) begin
        pend_d = pend_q - PendW'(1);
        acc_d  = acc_next;
        if (pend_q == PendW'(1)) begin
          emit    = 1'b1;
          cp_full = acc_next;
          acc_d   = '0;
        end
      end else begin
        pend_d = '0;
        acc_d  = '0;
        if (!in_byte_i[7]) begin
          emit    = 1'b1;
          cp_full = AccW'(in_byte_i);
        end else if (in_byte_i[7:5] == 3'b110) begin
          acc_d  = AccW'(in_byte_i[4:0]);
          pend_d = PendW'(1);
        end else if (in_byte_i[7:4] == 4'b1110) begin
          acc_d  = AccW'(in_byte_i[3:0]);
          pend_d = PendW'(2);
        end else if (in_byte_i[7:3] == 5'b11110) begin
          acc_d  = AccW'(in_byte_i[2:0]);
          pend_d = PendW'(3);
        end else if (in_byte_i[7:2] == 6'b111110) begin
          acc_d  = AccW'(in_byte_i[1:0]);
          pend_d = PendW'(4);
        end else if (in_byte_i[7:1] == 7'b1111110) begin
          acc_d  = AccW'(in_byte_i[0]);
          pend_d = PendW'(5);
        end
      end
      if (end_of_text_i) begin
        pend_d = '0;
        acc_d  = '0;
      end
    end
  end

  assign q_push_o = emit && (cp_full[AccW-1:CpW] == '0) && (cp_full[CpW-1:0] <= MaxPairCp);
  assign q_entry_o.cp = cp_full[CpW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// File: rtl/u8u16_fifo.sv
module u8u16_fifo import u8u16_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cp_entry_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output cp_entry_t rdata_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cp_entry_t       mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/u8u16_back.sv
module u8u16_back import u8u16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  cp_entry_t        q_entry_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [UnitW-1:0] code_unit_o,
  output logic             last_unit_o
);

  logic             out_valid_q, out_valid_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic             last_q, last_d;
  logic             lo_pend_q, lo_pend_d;
  logic [9:0]       lo_bits_q, lo_bits_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = out_free && !lo_pend_q && !q_empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    unit_d      = unit_q;
    last_d      = last_q;
    lo_pend_d   = lo_pend_q;
    lo_bits_d   = lo_bits_q;
    if (out_free) begin
      if (lo_pend_q) begin
        out_valid_d = 1'b1;
        unit_d      = LoSurrBase | UnitW'(lo_bits_q);
        last_d      = 1'b1;
        lo_pend_d   = 1'b0;
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        if (q_entry_i.cp[CpW-1:UnitW] == '0) begin
          unit_d = q_entry_i.cp[UnitW-1:0];
          last_d = 1'b1;
        end else begin
          unit_d    = HiSurrBase + UnitW'(q_entry_i.cp[CpW-1:10]) - HiSurrAdj;
          last_d    = 1'b0;
          lo_pend_d = 1'b1;
          lo_bits_d = q_entry_i.cp[9:0];
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = unit_q;
  assign last_unit_o = last_q;

  always_ff @(posedge clk_i) begin
    unit_q    <= unit_d;
    last_q    <= last_d;
    lo_bits_q <= lo_bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lo_pend_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      lo_pend_q   <= lo_pend_d;
    end
  end

endmodule

// File: rtl/utf8_to_utf16_stream_decoder_top.sv
// UTF-8 to UTF-16 stream decoder. Takes one UTF-8 byte per cycle (legacy
// lead bytes for sequences of up to six bytes are honored) and returns
// UTF-16 code units; a code point above 0xFFFF gives a high surrogate
// (last_unit_o low) and then a low surrogate, code points above 0xEFFFF and
// invalid leads give nothing, a bad continuation byte restarts as a lead, and
// end_of_text_i discards any unfinished sequence. The input side accepts one
// byte every cycle while the code point queue (QDepth entries) has room; the
// output register delivers one unit per cycle while out_stall_i is low, so
// a surrogate pair holds it for both units; the queue absorbs the difference.
module utf8_to_utf16_stream_decoder_top import u8u16_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [UnitW-1:0] code_unit_o,
  output logic             last_unit_o
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  cp_entry_t push_entry;
  cp_entry_t pop_entry;

  u8u16_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  u8u16_fifo #(
    .QDepth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (pop_entry),
    .empty_o (q_empty)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_entry_i   (pop_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .last_unit_o (last_unit_o)
  );

endmodule

// File: test/utf16_unit_checker.sv
`timescale 1ns / 100ps

module utf16_unit_checker import u8u16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [UnitW-1:0] code_unit_i,
  input  logic             last_unit_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             last;
  } utf16_unit_t;

  utf16_unit_t        units_due[$];
  logic [PendW-1:0]   cont_left;
  logic [AccW-1:0]    point_acc;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    cont_left    = '0;
    point_acc    = '0;
  end

  task automatic push_point(input logic [AccW-1:0] cp);
    utf16_unit_t hi;
    utf16_unit_t lo;
    if (cp <= 31'h0000_FFFF) begin
      units_due.push_back('{unit: cp[UnitW-1:0], last: 1'b1});
    end else if (cp <= {11'd0, MaxPairCp}) begin
      hi.unit = HiSurrBase + {6'd0, cp[19:10]} - HiSurrAdj;
      hi.last = 1'b0;
      lo.unit = LoSurrBase + {6'd0, cp[9:0]};
      lo.last = 1'b1;
      units_due.push_back(hi);
      units_due.push_back(lo);
    end
  endtask

  task automatic start_sequence(input logic [7:0] b);
    if (b < 8'h80) begin
      push_point({23'd0, b});
    end else if (b < 8'hC0 || b > 8'hFD) begin
      // drop invalid lead
    end else if (b < 8'hE0) begin
      point_acc = {26'd0, b[4:0]};
      cont_left = 3'd1;
    end else if (b < 8'hF0) begin
      point_acc = {27'd0, b[3:0]};
      cont_left = 3'd2;
    end else if (b < 8'hF8) begin
      point_acc = {28'd0, b[2:0]};
      cont_left = 3'd3;
    end else if (b < 8'hFC) begin
      point_acc = {29'd0, b[1:0]};
      cont_left = 3'd4;
    end else begin
      point_acc = {30'd0, b[0]};
      cont_left = 3'd5;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    if (cont_left != '0) begin
      if (b >= 8'h80 && b <= 8'hBF) begin
        point_acc = {point_acc[AccW-7:0], b[5:0] & ContMask[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == '0) begin
          push_point(point_acc);
          point_acc = '0;
        end
      end else begin
        cont_left = '0;
        point_acc = '0;
        start_sequence(b);
      end
    end else begin
      start_sequence(b);
    end
    if (eot) begin
      cont_left = '0;
      point_acc = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf16_unit_t want;
    if (!rst_ni) begin
      cont_left = '0;
      point_acc = '0;
      units_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_byte_i, end_of_text_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (units_due.size() == 0) begin
          $display("%0t: unexpected unit: expected none, got %h/%b",
                   $time, code_unit_i, last_unit_i);
          fail_count_o++;
        end else begin
          want = units_due.pop_front();
          if (code_unit_i !== want.unit || last_unit_i !== want.last) begin
            $display("%0t: unit mismatch: expected %h/%b, got %h/%b",
                     $time, want.unit, want.last, code_unit_i, last_unit_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = units_due.size();
  end

endmodule

// File: test/utf8_to_utf16_stream_decoder_top_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf16_stream_decoder_top_tb import u8u16_pkg::*;;

  localparam int unsigned RandomBytes = 1800;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i = 8'h00;
  logic             end_of_text_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [UnitW-1:0] code_unit_o;
  logic             last_unit_o;

  int fail_count;
  int units_pending;
  int sent_bytes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  utf8_to_utf16_stream_decoder_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .end_of_text_i,
    .out_valid_o,
    .out_stall_i,
    .code_unit_o,
    .last_unit_o
  );

  utf16_unit_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .in_byte_i,
    .end_of_text_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .code_unit_i   (code_unit_o),
    .last_unit_i   (last_unit_o),
    .fail_count_o  (fail_count),
    .pending_o     (units_pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("utf8_to_utf16_stream_decoder_top regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] lead_for(input int len);
    case (len)
      1: lead_for = 8'($urandom_range(8'h7F));
      2: lead_for = 8'hC0 + 8'($urandom_range(31));
      3: lead_for = 8'hE0 + 8'($urandom_range(15));
      4: lead_for = 8'hF0 + 8'($urandom_range(7));
      5: lead_for = 8'hF8 + 8'($urandom_range(3));
      default: lead_for = 8'hFC + 8'($urandom_range(1));
    endcase
  endfunction

  task automatic send_sequence();
    int kind;
    int pick;
    int len;
    int cut;
    logic [7:0] breaker;
    kind = $urandom_range(99);
    if (kind < 12) begin
      send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
    end else begin
      pick = $urandom_range(99);
      len = pick < 30 ? 1 : pick < 55 ? 2 : pick < 75 ? 3 : pick < 92 ? 4 : pick < 97 ? 5 : 6;
      if (kind < 24 && len > 1) begin
        cut = $urandom_range(len - 1, 1);
        send_byte(lead_for(len), 1'b0);
        for (int i = 1; i < cut; i++) begin
          send_byte(8'h80 + 8'($urandom_range(63)), 1'b0);
        end
        if ($urandom_range(3) == 0) begin
          // end text on a continuation byte, then a stray continuation
          send_byte(8'h80 + 8'($urandom_range(63)), 1'b1);
          send_byte(8'h80 + 8'($urandom_range(63)), 1'b0);
        end else begin
          case ($urandom_range(2))
            0: breaker = 8'($urandom_range(8'h7F));
            1: breaker = lead_for($urandom_range(6, 2));
            default: breaker = 8'hFE + 8'($urandom_range(1));
          endcase
          send_byte(breaker, 1'b0);
        end
      end else begin
        send_byte(lead_for(len), len == 1 && $urandom_range(15) == 0);
        for (int i = 1; i < len; i++) begin
          send_byte(8'h80 + 8'($urandom_range(63)), i == len - 1 && $urandom_range(15) == 0);
        end
      end
    end
  endtask

  logic [8:0] directed[] = '{
    9'h000, 9'h07F, 9'h080, 9'h0FF,
    9'h0C2, 9'h0A9,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0F4, 9'h090, 9'h080, 9'h080,
    9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h0E2, 9'h041,
    9'h0E2, 9'h182, 9'h082
  };

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_byte(directed[i][7:0], directed[i][8]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 30 : phase == 1 ? 74 : 0;
      recv_idle_pct = phase == 0 ? 74 : phase == 1 ? 30 : 0;
      while (sent_bytes < directed.size() + (phase + 1) * RandomBytes / 3) begin
        send_sequence();
      end
    end
    in_valid_i <= 1'b0;

    while (units_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("utf8_to_utf16_stream_decoder_top regression: pass");
    end else begin
      $display("utf8_to_utf16_stream_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_fifo.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_stream_decoder_top.sv
test/utf16_unit_checker.sv
test/utf8_to_utf16_stream_decoder_top_tb.sv
